// ----- sv/ptfl_pkg.sv -----
// Package for the page translation block: constants, request and result types.
package ptfl_pkg;
	localparam int PROCESSES  = 4;
	localparam int FRAME_BITS = 6;
	localparam int PAGE_BITS  = 12;
	localparam int VPN_BITS   = 20;
	localparam int PID_BITS   = 2;
	localparam int VA_BITS    = 32;
	localparam int PA_BITS    = 18;
	localparam int NFRAMES    = 1 << FRAME_BITS;
	localparam int MAP_ABITS  = PID_BITS + VPN_BITS;
	localparam int MAP_W      = FRAME_BITS + 1;
	localparam int OWN_W      = PID_BITS + VPN_BITS;
	localparam int PADDR_BITS = 1;
	localparam logic [PADDR_BITS-1:0] REG_POLICY = 1'b0;

	typedef struct packed {
		logic [PID_BITS-1:0] process_id;
		logic [VA_BITS-1:0]  virtual_addr;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [PA_BITS-1:0]  physical_addr;
		logic                evict_valid;
		logic [PID_BITS-1:0] evict_process;
		logic [VPN_BITS-1:0] evict_page;
	} res_t;
endpackage

// ----- sv/ptfl_ram.sv -----
// Generic single-port RAM with registered read data.
module ptfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- sv/page_translate_fifo_lru_replace.sv -----
// Page translation with FIFO or LRU frame replacement: top level.
// One request is accepted when start is high and busy is low; its result appears on the
// result ports for one cycle with done high, and cannot be held off. One sequencer walks
// the page map, frame owner and ring-link memories one state at a time: a FIFO hit goes
// straight to the result, an LRU hit relinks the used frame in the ring, and a fault
// fills the fill frame (once memory is full, the old owner is read first and its page is
// invalidated). After reset the block clears the page map one entry a cycle (PROCESSES *
// 2^VPN_BITS = 4194304 entries), holding busy high; register writes work.
module page_translate_fifo_lru_replace (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ptfl_pkg::req_t                 req,
	output logic                           done,
	output ptfl_pkg::res_t                 res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptfl_pkg::PADDR_BITS+1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import ptfl_pkg::*;

	localparam int FB = FRAME_BITS;
	localparam logic [4:0]
		S_CLR = 5'd0,  S_IDLE = 5'd1,  S_MRD = 5'd2,  S_MCHK = 5'd3,
		S_ORD = 5'd4,  S_OCHK = 5'd5,  S_INV = 5'd6,  S_FILL = 5'd7,
		S_NRD = 5'd8,  S_NUSE = 5'd9,  S_HL = 5'd10,  S_HR = 5'd11,
		S_H1 = 5'd12,  S_H2 = 5'd13,  S_H3 = 5'd14,  S_H4 = 5'd15,
		S_PRD = 5'd16, S_PUSE = 5'd17, S_H5 = 5'd18, S_OUT = 5'd19;

	logic [4:0] state_q;
	logic       policy_q;
	logic [MAP_ABITS-1:0] clr_q;
	logic [PID_BITS-1:0] pid_q;
	logic [VPN_BITS-1:0] vpn_q;
	logic [PAGE_BITS-1:0] off_q;
	logic [FB-1:0] frame_q, oldest_q, fill_q, l_q, r_q, n_q, pn_q;
	logic       full_q, hit_q, ev_q;
	logic [OWN_W-1:0] owner_q;

	// Memory ports.
	logic map_we; logic [MAP_ABITS-1:0] map_a; logic [MAP_W-1:0] map_wd, map_rd;
	logic own_we; logic [FB-1:0] own_a; logic [OWN_W-1:0] own_rd;
	logic nx_we; logic [FB-1:0] nx_a, nx_wd, nx_rd;
	logic pv_we; logic [FB-1:0] pv_a, pv_wd, pv_rd;
	// Ring links are valid once written; before that they read as the reset ring.
	logic [NFRAMES-1:0] nx_vld_q, pv_vld_q;
	logic [FB-1:0] nx_val, pv_val;
	logic [FB-1:0] nx_ra_q, pv_ra_q;

	ptfl_ram #(.WIDTH(MAP_W), .DEPTH(PROCESSES << VPN_BITS)) u_map (
		.clk, .we(map_we), .addr(map_a), .wdata(map_wd), .rdata(map_rd));
	ptfl_ram #(.WIDTH(OWN_W), .DEPTH(NFRAMES)) u_own (
		.clk, .we(own_we), .addr(own_a), .wdata({pid_q, vpn_q}), .rdata(own_rd));
	ptfl_ram #(.WIDTH(FB), .DEPTH(NFRAMES)) u_nx (
		.clk, .we(nx_we), .addr(nx_a), .wdata(nx_wd), .rdata(nx_rd));
	ptfl_ram #(.WIDTH(FB), .DEPTH(NFRAMES)) u_pv (
		.clk, .we(pv_we), .addr(pv_a), .wdata(pv_wd), .rdata(pv_rd));

	assign nx_val = nx_vld_q[nx_ra_q] ? nx_rd : nx_ra_q + FB'(1);
	assign pv_val = pv_vld_q[pv_ra_q] ? pv_rd : pv_ra_q - FB'(1);

	assign pready = 1'b1;
	assign prdata = {31'd0, policy_q};
	assign busy = (state_q != S_IDLE);

	always_comb begin
		map_we = 1'b0; map_a = {pid_q, vpn_q}; map_wd = {1'b1, frame_q};
		own_we = 1'b0; own_a = frame_q;
		nx_we = 1'b0; nx_a = frame_q; nx_wd = '0;
		pv_we = 1'b0; pv_a = frame_q; pv_wd = '0;
		unique case (state_q)
			S_CLR: begin map_we = 1'b1; map_a = clr_q; map_wd = '0; end
			S_IDLE: map_a = {req.process_id, req.virtual_addr[PAGE_BITS +: VPN_BITS]};
			S_ORD: own_a = fill_q;
			S_INV: begin map_we = 1'b1; map_a = owner_q; map_wd = '0; end
			S_FILL: begin map_we = 1'b1; own_we = 1'b1; end
			S_NRD: nx_a = oldest_q;
			S_HL: pv_a = frame_q;
			S_HR: begin pv_a = n_q; end
			S_H1: begin nx_we = 1'b1; nx_a = l_q; nx_wd = r_q; end
			S_H2: begin pv_we = 1'b1; pv_a = r_q; pv_wd = l_q; end
			S_H3: begin nx_we = 1'b1; nx_a = frame_q; nx_wd = n_q; pv_a = n_q; end
			S_PRD: pv_a = n_q;
			S_H4: begin pv_we = 1'b1; pv_a = frame_q; pv_wd = pn_q; end
			// When the used frame is the fill frame itself, its prev link now points
			// to itself, so the next link to close is its own.
			S_H5: begin
				pv_we = 1'b1; pv_a = n_q; pv_wd = frame_q;
				nx_we = 1'b1; nx_a = (n_q == frame_q) ? frame_q : pn_q; nx_wd = frame_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; policy_q <= 1'b0; clr_q <= '0;
			oldest_q <= '0; fill_q <= '0; full_q <= 1'b0;
			nx_vld_q <= '0; pv_vld_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			nx_ra_q <= nx_a; pv_ra_q <= pv_a;
			if (nx_we) nx_vld_q[nx_a] <= 1'b1;
			if (pv_we) pv_vld_q[pv_a] <= 1'b1;
			if (psel && penable && pwrite && paddr[PADDR_BITS+1:2] == REG_POLICY)
				policy_q <= pwdata[0];
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					pid_q <= req.process_id;
					vpn_q <= req.virtual_addr[PAGE_BITS +: VPN_BITS];
					off_q <= req.virtual_addr[PAGE_BITS-1:0];
					state_q <= S_MRD;
				end
				S_MRD: state_q <= S_MCHK;
				S_MCHK: begin
					ev_q <= 1'b0; owner_q <= '0;
					if (map_rd[FB]) begin
						hit_q <= 1'b1; frame_q <= map_rd[FB-1:0];
						if (!policy_q) state_q <= S_OUT;
						else if (map_rd[FB-1:0] == oldest_q && full_q) state_q <= S_NRD;
						else begin
							n_q <= fill_q; state_q <= S_HL;
						end
					end else begin
						hit_q <= 1'b0; frame_q <= fill_q;
						state_q <= full_q ? S_ORD : S_FILL;
					end
				end
				S_ORD: state_q <= S_OCHK;
				S_OCHK: begin
					ev_q <= 1'b1; owner_q <= own_rd; state_q <= S_INV;
				end
				S_INV: state_q <= S_FILL;
				S_FILL: state_q <= S_NRD;
				S_NRD: state_q <= S_NUSE;
				// nx_val here is ring_next[oldest] (or ring_next[frame] when frame==oldest).
				S_NUSE: begin
					if (hit_q) begin
						oldest_q <= nx_val; fill_q <= nx_val; state_q <= S_OUT;
					end else begin
						state_q <= S_HL; // reuse: read ring_next[frame] next
						l_q <= nx_val;   // ring_next[oldest]
					end
				end
				S_HL: begin
					if (!hit_q) begin
						// Fault: nx read above was ring_next[oldest]; now read ring_next[frame].
						state_q <= S_PRD; n_q <= l_q;
					end else state_q <= S_HR;
				end
				S_HR: begin
					l_q <= pv_val; r_q <= nx_val;
					if (frame_q == oldest_q && nx_val != fill_q) oldest_q <= nx_val;
					state_q <= S_H1;
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: state_q <= S_PUSE;
				S_PRD: state_q <= S_PUSE;
				S_PUSE: begin
					if (hit_q) begin
						pn_q <= pv_val; state_q <= S_H4;
					end else begin
						// pv_ra_q was n_q = ring_next[oldest]; nx_ra_q is frame.
						if (frame_q == FB'(NFRAMES-1)) full_q <= 1'b1;
						if (policy_q && full_q) begin
							oldest_q <= n_q; fill_q <= n_q;
						end else if (policy_q && frame_q == FB'(NFRAMES-1)) begin
							fill_q <= oldest_q;
						end else fill_q <= nx_val;
						state_q <= S_OUT;
					end
				end
				S_H4: state_q <= S_H5;
				S_H5: state_q <= S_OUT;
				S_OUT: begin
					done <= 1'b1;
					res.hit <= hit_q;
					res.physical_addr <= PA_BITS'({frame_q, off_q});
					res.evict_valid <= ev_q;
					res.evict_process <= owner_q[OWN_W-1 -: PID_BITS];
					res.evict_page <= owner_q[VPN_BITS-1:0];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
